[hw/rtl/sdx_pkg.sv]
// Shared types, constants and letter classification for the soundex encoder.
`timescale 1ns / 1ps

package sdx_pkg;

    // Default total code length (letter plus digits)
    localparam int CODE_LENGTH = 4;
    // Digit fields in one result
    localparam int DIGIT_SLOTS = 3;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One input item: a name byte and its end-of-name flag
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } sdx_in_t;

    // One result item
    typedef struct packed {
        logic [6:0] first_letter;
        logic [2:0] digit_one;
        logic [2:0] digit_two;
        logic [2:0] digit_three;
        logic       no_letter_error;
    } sdx_out_t;

    // Classified byte as handed from front to back
    typedef struct packed {
        logic       is_letter;
        logic [6:0] letter;
        logic [2:0] code;
        logic       last;
    } sdx_cls_t;

    // Map an upper-case letter to its soundex code
    function automatic logic [2:0] letter_code(input logic [7:0] upper);
        logic [2:0] code;
        code = 3'd0;
        if (upper inside {"B", "F", "P", "V"}) begin
            code = 3'd1;
        end else if (upper inside {"C", "G", "J", "K", "Q", "S", "X", "Z"}) begin
            code = 3'd2;
        end else if (upper inside {"D", "T"}) begin
            code = 3'd3;
        end else if (upper == "L") begin
            code = 3'd4;
        end else if (upper inside {"M", "N"}) begin
            code = 3'd5;
        end else if (upper == "R") begin
            code = 3'd6;
        end
        return code;
    endfunction

endpackage

[hw/rtl/soundex_encoder_top.sv]
// Top level of the soundex encoder: front, queue and back joined together.
//
// Usage:
//   Input channel: one name byte per item on char_item, with last_char set
//   on the final byte. An item is taken at a clock edge with push high and
//   full low. Bytes other than ASCII letters are skipped.
//   Result channel: one item per name on code_item, present while empty is
//   low and taken at a clock edge with pop high and empty low. It carries
//   the upper-case first letter and three digits, or no_letter_error set.
//   Result path: a name's last byte is written into the queue, and the back
//   end then takes it and registers the result; empty falls at that edge.
//   Throughput: one byte per cycle while full is low; the back end updates
//   the running code by compare and update, fed from a two-entry queue.
//   Stall: while a result waits, the back end keeps taking bytes that do
//   not end a name; a name's last byte waits in the queue until the result
//   slot is free, and full rises once the queue fills.
//   Reset: rst_n low clears the queue, the running code and the result
//   slot; no result is pending afterwards.
`timescale 1ns / 1ps

module soundex_encoder_top #(
    parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sdx_pkg::sdx_in_t  char_item,
    output logic              empty,
    input  logic              pop,
    output sdx_pkg::sdx_out_t code_item
);

    logic              q_wr;
    logic              q_rd;
    logic              q_valid;
    sdx_pkg::sdx_cls_t wr_item;
    sdx_pkg::sdx_cls_t rd_item;

    sdx_front u_front (
        .push      (push),
        .char_item (char_item),
        .q_full    (full),
        .q_wr      (q_wr),
        .q_item    (wr_item)
    );

    sdx_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (wr_item),
        .q_full  (full),
        .rd      (q_rd),
        .rd_item (rd_item),
        .q_valid (q_valid)
    );

    sdx_back #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (rd_item),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .code_item (code_item)
    );

endmodule

[hw/rtl/sdx_front.sv]
// Front end: accepts name bytes, folds case and looks up the letter code.
`timescale 1ns / 1ps

module sdx_front (
    input  logic             push,
    input  sdx_pkg::sdx_in_t char_item,
    input  logic             q_full,
    output logic             q_wr,
    output sdx_pkg::sdx_cls_t q_item
);

    logic [7:0] upper;
    logic       is_letter;

    // Fold lower case to upper case, flag letters
    always_comb
    begin
        upper     = char_item.character;
        is_letter = 1'b0;
        if (char_item.character inside {[8'h61:8'h7A]}) begin
            upper     = char_item.character - 8'd32;
            is_letter = 1'b1;
        end else if (char_item.character inside {[8'h41:8'h5A]}) begin
            is_letter = 1'b1;
        end
    end

    // Build the classified item and write it while the queue has room
    always_comb
    begin
        q_item.is_letter = is_letter;
        q_item.letter    = upper[6:0];
        q_item.code      = sdx_pkg::letter_code(upper);
        q_item.last      = char_item.last_char;
        q_wr             = push && !q_full;
    end

endmodule

[hw/rtl/sdx_queue.sv]
// Short first-in first-out queue between front and back.
`timescale 1ns / 1ps

module sdx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  sdx_pkg::sdx_cls_t wr_item,
    output logic              q_full,
    input  logic              rd,
    output sdx_pkg::sdx_cls_t rd_item,
    output logic              q_valid
);

    localparam int DEPTH = sdx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sdx_pkg::sdx_cls_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written item
    always_ff @(posedge clk)
    begin
        if (wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (count_reg != FULL_CNT))
        else $error("write into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> (count_reg != '0))
        else $error("read from empty queue");
`endif

endmodule

[hw/rtl/sdx_back.sv]
// Back end: coalesces codes, keeps digits and holds the finished result.
`timescale 1ns / 1ps

module sdx_back #(
    parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sdx_pkg::sdx_cls_t q_item,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output sdx_pkg::sdx_out_t code_item
);

    localparam int SLOTS = sdx_pkg::DIGIT_SLOTS;
    localparam int KEPT_INT = (CODE_LENGTH - 1 > SLOTS) ? SLOTS :
                              ((CODE_LENGTH - 1 < 0) ? 0 : CODE_LENGTH - 1);
    localparam logic [1:0] KEPT_DIGITS = 2'(KEPT_INT);

    logic              letter_seen_reg, letter_seen_next;
    logic [6:0]        kept_letter_reg, kept_letter_next;
    logic [2:0]        previous_code_reg, previous_code_next;
    logic [1:0]        digits_emitted_reg, digits_emitted_next;
    logic [2:0]        code_digits_reg [SLOTS];
    logic [2:0]        code_digits_next [SLOTS];
    logic              out_valid_reg, out_valid_next;
    sdx_pkg::sdx_out_t out_reg, out_next;
    logic              take;
    logic              done;

    // Take an item unless it would finish a name while the result slot is held and not popped
    assign take  = q_valid && (!q_item.last || !out_valid_reg || pop);
    assign done  = take && q_item.last;
    assign q_rd  = take;
    assign empty = !out_valid_reg;
    assign code_item = out_reg;

    always_comb
    begin
        letter_seen_next    = letter_seen_reg;
        kept_letter_next    = kept_letter_reg;
        previous_code_next  = previous_code_reg;
        digits_emitted_next = digits_emitted_reg;
        code_digits_next    = code_digits_reg;
        out_valid_next      = out_valid_reg;
        out_next            = out_reg;

        // Update the running code with a letter
        if (take && q_item.is_letter) begin
            if (!letter_seen_reg) begin
                letter_seen_next   = 1'b1;
                kept_letter_next   = q_item.letter;
                previous_code_next = q_item.code;
            end else if (q_item.code != previous_code_reg) begin
                previous_code_next = q_item.code;
                if (q_item.code != 3'd0 && digits_emitted_reg < KEPT_DIGITS) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (digits_emitted_reg == 2'(i)) begin
                            code_digits_next[i] = q_item.code;
                        end
                    end
                    digits_emitted_next = digits_emitted_reg + 2'd1;
                end
            end
        end

        // Drop a delivered result
        if (pop && out_valid_reg) begin
            out_valid_next = 1'b0;
        end

        // Form the result on the last byte and clear the running state
        if (done) begin
            out_valid_next = 1'b1;
            if (letter_seen_next) begin
                out_next.first_letter    = kept_letter_next;
                out_next.digit_one       = code_digits_next[0];
                out_next.digit_two       = code_digits_next[1];
                out_next.digit_three     = code_digits_next[2];
                out_next.no_letter_error = 1'b0;
            end else begin
                out_next = '0;
                out_next.no_letter_error = 1'b1;
            end
            letter_seen_next    = 1'b0;
            kept_letter_next    = '0;
            previous_code_next  = '0;
            digits_emitted_next = '0;
            for (int i = 0; i < SLOTS; i++) begin
                code_digits_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            letter_seen_reg    <= 1'b0;
            kept_letter_reg    <= '0;
            previous_code_reg  <= '0;
            digits_emitted_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                code_digits_reg[i] <= '0;
            end
            out_valid_reg      <= 1'b0;
        end else begin
            letter_seen_reg    <= letter_seen_next;
            kept_letter_reg    <= kept_letter_next;
            previous_code_reg  <= previous_code_next;
            digits_emitted_reg <= digits_emitted_next;
            code_digits_reg    <= code_digits_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef ASSERT_OFF
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        digits_emitted_reg <= KEPT_DIGITS)
        else $error("digit count beyond kept digits");
    a_clear_after_name: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!letter_seen_reg && digits_emitted_reg == 2'd0
                  && previous_code_reg == 3'd0))
        else $error("state not cleared after a name");
    a_error_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.no_letter_error) |-> (out_reg.first_letter == 7'd0))
        else $error("error result carries a letter");
    a_no_digits_without_letter: assert property (@(posedge clk) disable iff (!rst_n)
        !letter_seen_reg |-> (digits_emitted_reg == 2'd0))
        else $error("digits stored before a first letter");
`endif

endmodule
